@@ src/clt_pkg.sv @@
package clt_pkg;

	localparam int MAX_ARGS = 255;
	localparam int CountLimit = (MAX_ARGS > 255) ? 255 : MAX_ARGS;
	localparam logic [7:0] COUNT_LIMIT = 8'(CountLimit);

	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;

	typedef enum logic [2:0] {
		MODE_NORMAL,
		MODE_ESC,
		MODE_QUOTE,
		MODE_QESC,
		MODE_ERROR
	} scan_mode_t;

	typedef enum logic [1:0] {
		ERR_NONE,
		ERR_END,
		ERR_ESC,
		ERR_QUOTE
	} err_code_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       char_valid;
		logic       token_end;
		logic       line_done;
		err_code_t  error_code;
		logic [7:0] arg_count;
		logic       last_result;
	} tok_res_t;

	// pre_bs: a kept backslash goes out ahead of res
	typedef struct packed {
		logic     pre_bs;
		tok_res_t res;
	} tok_rec_t;

	function automatic logic is_escapable(input logic [7:0] ch);
		return (ch == CH_SPACE) || (ch == CH_BSLASH) || (ch == CH_SQUOTE) || (ch == CH_DQUOTE);
	endfunction

endpackage

@@ src/clt_in_if.sv @@
interface clt_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;
	logic       end_of_line;

	modport source (output valid, output in_char, output end_of_line, input ready);
	modport sink (input valid, input in_char, input end_of_line, output ready);
endinterface

@@ src/clt_out_if.sv @@
interface clt_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       char_valid;
	logic       token_end;
	logic       line_done;
	logic [1:0] error_code;
	logic [7:0] arg_count;
	logic       last_result;

	modport source (output valid, output out_char, output char_valid, output token_end,
		output line_done, output error_code, output arg_count, output last_result,
		input ready);
	modport sink (input valid, input out_char, input char_valid, input token_end,
		input line_done, input error_code, input arg_count, input last_result,
		output ready);
endinterface

@@ src/command_line_tokenizer.sv @@
// Splits a command line, one byte per word on line_bytes, into arguments on tokens.
// One byte is taken every cycle while the queue is not full. Quotes and a held backslash
// give no word; a space gives a token end; end_of_line gives the line_done word and clears
// the count for the next line. A backslash held inside quotes and followed by a byte other
// than the closing quote or another backslash (or by end of line) gives two words, a
// backslash and then the word for that byte; the two-entry queue between the scanner and
// the output stage absorbs the extra word, and input stalls only while that queue is full.
// A word is registered in the queue when its byte is accepted, and then in the output
// register, before it is valid on tokens.
module command_line_tokenizer import clt_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	clt_in_if.sink    line_bytes,
	clt_out_if.source tokens
);

	logic     push;
	tok_rec_t push_rec;
	logic     q_full;
	logic     head_valid;
	tok_rec_t head_rec;
	logic     pop;

	clt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.line_bytes (line_bytes),
		.q_full     (q_full),
		.push       (push),
		.rec        (push_rec)
	);

	clt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_rec   (push_rec),
		.full       (q_full),
		.head_valid (head_valid),
		.head_rec   (head_rec),
		.pop        (pop)
	);

	clt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_rec   (head_rec),
		.pop        (pop),
		.tokens     (tokens)
	);

endmodule

@@ src/clt_front.sv @@
module clt_front import clt_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	clt_in_if.sink         line_bytes,
	input  logic           q_full,
	output logic           push,
	output tok_rec_t       rec
);

	scan_mode_t mode_q, mode_d;
	logic       quote_dbl_q, quote_dbl_d;
	logic [7:0] args_q, args_d;
	err_code_t  held_err_q, held_err_d;

	logic       accept;
	logic       eol;
	logic [7:0] ch;
	logic [7:0] quote_ch;
	logic [7:0] args_inc;

	assign line_bytes.ready = !q_full;
	assign accept   = line_bytes.valid && line_bytes.ready;
	assign eol      = line_bytes.end_of_line;
	assign ch       = line_bytes.in_char;
	assign quote_ch = quote_dbl_q ? CH_DQUOTE : CH_SQUOTE;
	assign args_inc = (args_q < COUNT_LIMIT) ? args_q + 8'd1 : args_q;

	// next state
	always_comb begin
		mode_d      = mode_q;
		quote_dbl_d = quote_dbl_q;
		args_d      = args_q;
		held_err_d  = held_err_q;
		if (accept) begin
			if (eol) begin
				mode_d      = MODE_NORMAL;
				quote_dbl_d = 1'b0;
				args_d      = '0;
				held_err_d  = ERR_NONE;
			end else begin
				case (mode_q)
					MODE_NORMAL: begin
						if (ch == CH_BSLASH) begin
							mode_d = MODE_ESC;
						end else if (ch == CH_SQUOTE || ch == CH_DQUOTE) begin
							quote_dbl_d = (ch == CH_DQUOTE);
							mode_d      = MODE_QUOTE;
						end else if (ch == CH_SPACE) begin
							args_d = args_inc;
						end
					end
					MODE_ESC: begin
						if (is_escapable(ch)) begin
							mode_d = MODE_NORMAL;
						end else begin
							held_err_d = ERR_ESC;
							mode_d     = MODE_ERROR;
						end
					end
					MODE_QUOTE: begin
						if (ch == quote_ch) begin
							mode_d = MODE_NORMAL;
						end else if (ch == CH_BSLASH) begin
							mode_d = MODE_QESC;
						end
					end
					MODE_QESC: begin
						// a second backslash stays held
						if (ch != CH_BSLASH) begin
							mode_d = MODE_QUOTE;
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// result word for this byte
	always_comb begin
		push = 1'b0;
		rec  = '0;
		rec.res.arg_count   = args_q;
		rec.res.last_result = 1'b1;
		case (mode_q)
			MODE_NORMAL: begin
				if (eol) begin
					push = 1'b1;
					rec.res.token_end = 1'b1;
					rec.res.line_done = 1'b1;
					rec.res.arg_count = args_inc;
				end else if (ch == CH_SPACE) begin
					push = 1'b1;
					rec.res.token_end = 1'b1;
					rec.res.arg_count = args_inc;
				end else if (ch != CH_BSLASH && ch != CH_SQUOTE && ch != CH_DQUOTE) begin
					push = 1'b1;
					rec.res.out_char   = ch;
					rec.res.char_valid = 1'b1;
				end
			end
			MODE_ESC: begin
				push = 1'b1;
				if (eol) begin
					rec.res.line_done  = 1'b1;
					rec.res.error_code = ERR_END;
				end else if (is_escapable(ch)) begin
					rec.res.out_char   = ch;
					rec.res.char_valid = 1'b1;
				end else begin
					rec.res.error_code = ERR_ESC;
				end
			end
			MODE_QUOTE: begin
				if (eol) begin
					push = 1'b1;
					rec.res.line_done  = 1'b1;
					rec.res.error_code = ERR_QUOTE;
				end else if (ch != quote_ch && ch != CH_BSLASH) begin
					push = 1'b1;
					rec.res.out_char   = ch;
					rec.res.char_valid = 1'b1;
				end
			end
			MODE_QESC: begin
				push = 1'b1;
				if (eol) begin
					rec.pre_bs = 1'b1;
					rec.res.line_done  = 1'b1;
					rec.res.error_code = ERR_QUOTE;
				end else begin
					rec.pre_bs = (ch != quote_ch) && (ch != CH_BSLASH);
					rec.res.out_char   = ch;
					rec.res.char_valid = 1'b1;
				end
			end
			default: begin
				if (eol) begin
					push = 1'b1;
					rec.res.line_done  = 1'b1;
					rec.res.error_code = held_err_q;
				end
			end
		endcase
		push = push && accept;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_NORMAL;
			quote_dbl_q <= 1'b0;
			args_q      <= '0;
			held_err_q  <= ERR_NONE;
		end else begin
			mode_q      <= mode_d;
			quote_dbl_q <= quote_dbl_d;
			args_q      <= args_d;
			held_err_q  <= held_err_d;
		end
	end

endmodule

@@ src/clt_queue.sv @@
module clt_queue import clt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  tok_rec_t push_rec,
	output logic     full,
	output logic     head_valid,
	output tok_rec_t head_rec,
	input  logic     pop
);

	tok_rec_t   entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_rec   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ src/clt_back.sv @@
module clt_back import clt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     head_valid,
	input  tok_rec_t head_rec,
	output logic     pop,
	clt_out_if.source tokens
);

	tok_res_t out_q;
	logic     out_valid_q;
	logic     pre_done_q;
	logic     load;
	logic     send_pre;
	tok_res_t bs_res;

	assign load     = head_valid && (!out_valid_q || tokens.ready);
	assign send_pre = head_rec.pre_bs && !pre_done_q;
	assign pop      = load && !send_pre;

	always_comb begin
		bs_res             = '0;
		bs_res.out_char    = CH_BSLASH;
		bs_res.char_valid  = 1'b1;
		bs_res.arg_count   = head_rec.res.arg_count;
		bs_res.last_result = 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_q <= send_pre ? bs_res : head_rec.res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			pre_done_q  <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				pre_done_q  <= send_pre;
			end else if (tokens.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign tokens.valid       = out_valid_q;
	assign tokens.out_char    = out_q.out_char;
	assign tokens.char_valid  = out_q.char_valid;
	assign tokens.token_end   = out_q.token_end;
	assign tokens.line_done   = out_q.line_done;
	assign tokens.error_code  = out_q.error_code;
	assign tokens.arg_count   = out_q.arg_count;
	assign tokens.last_result = out_q.last_result;

endmodule

@@ src/clt_checker.sv @@
module clt_checker import clt_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_char,
	input logic       char_valid,
	input logic       token_end,
	input logic       line_done,
	input logic [1:0] error_code,
	input logic [7:0] arg_count,
	input logic       last_result
);

	// hold a stalled word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(token_end)
			&& $stable(line_done) && $stable(error_code) && $stable(arg_count))
		else $error("stalled output word changed");

	a_line_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_done |-> last_result)
		else $error("line_done word is not the last word of its byte");

	a_char_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !char_valid |-> out_char == 8'd0)
		else $error("out_char nonzero without char_valid");

	a_err_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_code != ERR_NONE |-> !char_valid && !token_end)
		else $error("error word carries a character or token end");

	a_clean_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_done && error_code == ERR_NONE |-> token_end && arg_count != 8'd0)
		else $error("clean line end without counted token end");

endmodule

bind command_line_tokenizer clt_checker u_clt_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (tokens.valid),
	.out_ready   (tokens.ready),
	.out_char    (tokens.out_char),
	.char_valid  (tokens.char_valid),
	.token_end   (tokens.token_end),
	.line_done   (tokens.line_done),
	.error_code  (tokens.error_code),
	.arg_count   (tokens.arg_count),
	.last_result (tokens.last_result)
);
